>>> hdl/r4d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r4d_pkg
// Shared types and sign/select tables for the 4D rotor sandwich product.
// ----------------------------------------------------------------------------
package r4d_pkg;

    localparam int NUM_COEF  = 8;
    localparam int NUM_DIM   = 4;
    localparam int NUM_TERM  = 8;
    localparam int NUM_STAGE = 5;
    localparam int REG_IDX_W = 3;

    typedef logic [REG_IDX_W-1:0] coef_idx_t;

    localparam coef_idx_t REG_SCALAR = 3'd0;
    localparam coef_idx_t REG_XY     = 3'd1;
    localparam coef_idx_t REG_XZ     = 3'd2;
    localparam coef_idx_t REG_XW     = 3'd3;
    localparam coef_idx_t REG_YZ     = 3'd4;
    localparam coef_idx_t REG_YW     = 3'd5;
    localparam coef_idx_t REG_ZW     = 3'd6;
    localparam coef_idx_t REG_PSEUDO = 3'd7;

    // intermediate terms: sx sy sz sw xyz xyw xzw yzw, over x y z w
    localparam coef_idx_t C1_SEL [NUM_TERM][NUM_DIM] = '{
        '{REG_SCALAR, REG_XY,     REG_XZ,     REG_XW    },
        '{REG_XY,     REG_SCALAR, REG_YZ,     REG_YW    },
        '{REG_XZ,     REG_YZ,     REG_SCALAR, REG_ZW    },
        '{REG_XW,     REG_YW,     REG_ZW,     REG_SCALAR},
        '{REG_YZ,     REG_XZ,     REG_XY,     REG_PSEUDO},
        '{REG_YW,     REG_XW,     REG_PSEUDO, REG_XY    },
        '{REG_ZW,     REG_PSEUDO, REG_XW,     REG_XZ    },
        '{REG_PSEUDO, REG_ZW,     REG_YW,     REG_YZ    }
    };

    localparam bit C1_NEG [NUM_TERM][NUM_DIM] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b1, 1'b0}
    };

    // output coordinates x y z w, over the eight intermediate terms
    localparam coef_idx_t C2_SEL [NUM_DIM][NUM_TERM] = '{
        '{REG_SCALAR, REG_XY, REG_XZ, REG_XW, REG_YZ, REG_YW, REG_ZW, REG_PSEUDO},
        '{REG_XY, REG_SCALAR, REG_YZ, REG_YW, REG_XZ, REG_XW, REG_PSEUDO, REG_ZW},
        '{REG_XZ, REG_YZ, REG_SCALAR, REG_ZW, REG_XY, REG_PSEUDO, REG_XW, REG_YW},
        '{REG_XW, REG_YW, REG_ZW, REG_SCALAR, REG_PSEUDO, REG_XY, REG_XZ, REG_YZ}
    };

    localparam bit C2_NEG [NUM_DIM][NUM_TERM] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1},
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}
    };

endpackage

>>> hdl/r4d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r4d_if
// Valid/ready stream interfaces for input points and rotated results.
// ----------------------------------------------------------------------------
interface r4d_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic signed [COORD_WIDTH-1:0] in_w;

    modport source (output valid, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface r4d_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic signed [COORD_WIDTH-1:0] out_w;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

>>> hdl/rotor4d_vector_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor4d_vector_rotate
// Rotates a stream of 4D Q16.16 points by a Q2.14 rotor (R v R~). The block
// is a five-stage pipeline: coefficient-by-coordinate products, eight rounded
// intermediate terms, coefficient-by-term products, output sums, then
// rounding and saturation. It takes one point per cycle while the output does
// not stall. Backpressure on the output stalls only as far back as needed:
// empty stages keep filling. Rotor registers reset to the identity rotor and
// are written through cfg_we/cfg_index/cfg_data; the user must write them only
// while no transaction is in flight, since the block does not enforce this.
// The two registered multiplier banks hold 32 multipliers each.
// ----------------------------------------------------------------------------
module rotor4d_vector_rotate
    import r4d_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_WIDTH-1:0] cfg_data,
    r4d_in_if.sink                in_pt,
    r4d_out_if.source             out_pt
);

    localparam int F   = COEF_WIDTH - 2;
    localparam int P1W = COORD_WIDTH + COEF_WIDTH;
    localparam int S1W = P1W + 3;
    localparam int TW  = S1W - F;
    localparam int P2W = TW + COEF_WIDTH;
    localparam int S2W = P2W + 4;
    localparam int RW  = S2W - F;

    localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (F - 1);
    localparam logic signed [S2W-1:0] HALF2 = S2W'(1) << (F - 1);
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH-1:0]  coef_reg [NUM_COEF];
    logic signed [COORD_WIDTH-1:0] vin      [NUM_DIM];

    logic [NUM_STAGE-1:0] vld_reg;
    logic [NUM_STAGE-1:0] adv;

    logic signed [P1W-1:0]         p1_reg   [NUM_COEF][NUM_DIM];
    logic signed [TW-1:0]          term_reg [NUM_TERM];
    logic signed [TW-1:0]          term_next[NUM_TERM];
    logic signed [P2W-1:0]         p2_reg   [NUM_DIM][NUM_TERM];
    logic signed [S2W-1:0]         sum_reg  [NUM_DIM];
    logic signed [S2W-1:0]         sum_next [NUM_DIM];
    logic signed [COORD_WIDTH-1:0] res_reg  [NUM_DIM];
    logic signed [COORD_WIDTH-1:0] res_next [NUM_DIM];
    logic                          sat_reg;
    logic                          sat_next;

    // rotor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COEF; c++)
            begin
                coef_reg[c] <= (c == int'(REG_SCALAR)) ? COEF_WIDTH'(1 << F) : '0;
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // stall chain: a stage advances when empty or when the next one advances
    always_comb
    begin
        adv[NUM_STAGE-1] = !vld_reg[NUM_STAGE-1] || out_pt.ready;
        for (int s = NUM_STAGE - 2; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_pt.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_pt.valid;
            end
            for (int s = 1; s < NUM_STAGE; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        vin[0] = in_pt.in_x;
        vin[1] = in_pt.in_y;
        vin[2] = in_pt.in_z;
        vin[3] = in_pt.in_w;
    end

    // intermediate terms: signed sum of four products, rounded half up
    always_comb
    begin
        logic signed [S1W-1:0] acc1;
        for (int t = 0; t < NUM_TERM; t++)
        begin
            acc1 = HALF1;
            for (int j = 0; j < NUM_DIM; j++)
            begin
                if (C1_NEG[t][j])
                    acc1 = acc1 - S1W'(p1_reg[C1_SEL[t][j]][j]);
                else
                    acc1 = acc1 + S1W'(p1_reg[C1_SEL[t][j]][j]);
            end
            term_next[t] = acc1[S1W-1:F];
        end
    end

    always_comb
    begin
        logic signed [S2W-1:0] acc2;
        for (int o = 0; o < NUM_DIM; o++)
        begin
            acc2 = '0;
            for (int t = 0; t < NUM_TERM; t++)
            begin
                if (C2_NEG[o][t])
                    acc2 = acc2 - S2W'(p2_reg[o][t]);
                else
                    acc2 = acc2 + S2W'(p2_reg[o][t]);
            end
            sum_next[o] = acc2;
        end
    end

    // round and clip each output coordinate
    always_comb
    begin
        logic signed [S2W-1:0] rnd;
        logic signed [RW-1:0]  r;
        logic [RW-COORD_WIDTH:0] hi;
        logic ovf;
        sat_next = 1'b0;
        for (int o = 0; o < NUM_DIM; o++)
        begin
            rnd = sum_reg[o] + HALF2;
            r   = rnd[S2W-1:F];
            hi  = r[RW-1:COORD_WIDTH-1];
            ovf = !((&hi) || !(|hi));
            if (ovf)
                res_next[o] = r[RW-1] ? CMIN : CMAX;
            else
                res_next[o] = r[COORD_WIDTH-1:0];
            sat_next = sat_next | ovf;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int c = 0; c < NUM_COEF; c++)
            begin
                for (int j = 0; j < NUM_DIM; j++)
                begin
                    p1_reg[c][j] <= coef_reg[c] * vin[j];
                end
            end
        end
        if (adv[1])
        begin
            term_reg <= term_next;
        end
        if (adv[2])
        begin
            for (int o = 0; o < NUM_DIM; o++)
            begin
                for (int t = 0; t < NUM_TERM; t++)
                begin
                    p2_reg[o][t] <= term_reg[t] * coef_reg[C2_SEL[o][t]];
                end
            end
        end
        if (adv[3])
        begin
            sum_reg <= sum_next;
        end
        if (adv[4])
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign out_pt.valid     = vld_reg[NUM_STAGE-1];
    assign out_pt.out_x     = res_reg[0];
    assign out_pt.out_y     = res_reg[1];
    assign out_pt.out_z     = res_reg[2];
    assign out_pt.out_w     = res_reg[3];
    assign out_pt.saturated = sat_reg;

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_pt.ready |-> (out_pt.valid && !out_pt.ready))
        else $error("input stalled without output backpressure");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pt.valid && out_pt.saturated) |->
            (out_pt.out_x == CMAX || out_pt.out_x == CMIN ||
             out_pt.out_y == CMAX || out_pt.out_y == CMIN ||
             out_pt.out_z == CMAX || out_pt.out_z == CMIN ||
             out_pt.out_w == CMAX || out_pt.out_w == CMIN))
        else $error("saturated flag without a clipped coordinate");

    a_fill_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_pt.valid && in_pt.ready) |=> vld_reg[0])
        else $error("accepted transaction missing from first stage");

endmodule

>>> bench/tb_rotor4d_vector_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotor4d_vector_rotate
// Streams 4D points through the rotor sandwich pipeline under several rotor
// settings (identity, extreme, tiny, single-plane and random, normalized or
// not). Each accepted point is rotated by an independent bit-exact predictor
// and every result is checked in order, including the saturation flag.
// Sender bursts, receiver stall patterns and long hold-offs exercise the
// valid/ready flow control.
// ----------------------------------------------------------------------------
module tb_rotor4d_vector_rotate;
    import r4d_pkg::*;

    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH  = 16;
    localparam int FRAC        = COEF_WIDTH - 2;
    localparam int SETTLE      = NUM_STAGE + 3;
    localparam int MAX_REPORTS = 40;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef coef_t rotor_t [NUM_COEF];

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
    } point_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
        logic   sat;
    } rotated_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

    localparam coef_t ONE   = coef_t'(1 << FRAC);
    localparam coef_t COS45 = 16'sd11585;
    localparam coef_t C_MAX = 16'sh7FFF;
    localparam coef_t C_MIN = 16'sh8000;
    localparam coord_t P_MAX = 32'sh7FFFFFFF;
    localparam coord_t P_MIN = 32'sh80000000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    coef_idx_t cfg_index;
    coef_t     cfg_data;

    r4d_in_if  #(.COORD_WIDTH(COORD_WIDTH)) pt_in ();
    r4d_out_if #(.COORD_WIDTH(COORD_WIDTH)) pt_out ();

    rotor4d_vector_rotate #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_pt    (pt_in),
        .out_pt   (pt_out)
    );

    rotor_t      active_rotor;
    rotated_t    expected_points [$];
    int          points_accepted;
    int          results_checked;
    int          sat_results;
    int          mismatch_count;
    int          rotor_settings;
    int          stall_run;
    int          longest_stall;
    bit          sender_idles;
    bit          offering;
    int          burst_left;
    rx_mode_e    rx_mode;
    int          hold_len;
    int          hold_seq;
    int          hold_seen;
    int          hold_left;
    logic [15:0] rx_pattern = 16'b1011_0111_0010_1101;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("%0t: timeout with %0d results pending", $time, expected_points.size());
        $display("rotor4d_vector_rotate: mismatch");
        $finish;
    end

    function automatic longint round_frac(longint acc);
        return (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic rotated_t rotate_point(point_t p, rotor_t r);
        longint   a, bxy, bxz, bxw, byz, byw, bzw, ps;
        longint   x, y, z, w;
        longint   t [NUM_TERM];
        longint   acc [NUM_DIM];
        rotated_t res;
        int       i;
        a   = r[REG_SCALAR];
        bxy = r[REG_XY];
        bxz = r[REG_XZ];
        bxw = r[REG_XW];
        byz = r[REG_YZ];
        byw = r[REG_YW];
        bzw = r[REG_ZW];
        ps  = r[REG_PSEUDO];
        x = p.x;
        y = p.y;
        z = p.z;
        w = p.w;
        t[0] = round_frac(a * x + bxy * y + bxz * z + bxw * w);
        t[1] = round_frac(-bxy * x + a * y + byz * z + byw * w);
        t[2] = round_frac(-bxz * x - byz * y + a * z + bzw * w);
        t[3] = round_frac(-bxw * x - byw * y - bzw * z + a * w);
        t[4] = round_frac(byz * x - bxz * y + bxy * z + ps * w);
        t[5] = round_frac(byw * x - bxw * y - ps * z + bxy * w);
        t[6] = round_frac(bzw * x + ps * y - bxw * z + bxz * w);
        t[7] = round_frac(-ps * x + bzw * y - byw * z + byz * w);
        acc[0] = a * t[0] + bxy * t[1] + bxz * t[2] + bxw * t[3]
               + byz * t[4] + byw * t[5] + bzw * t[6] + ps * t[7];
        acc[1] = -bxy * t[0] + a * t[1] + byz * t[2] + byw * t[3]
               - bxz * t[4] - bxw * t[5] - ps * t[6] + bzw * t[7];
        acc[2] = -bxz * t[0] - byz * t[1] + a * t[2] + bzw * t[3]
               + bxy * t[4] + ps * t[5] - bxw * t[6] - byw * t[7];
        acc[3] = -bxw * t[0] - byw * t[1] - bzw * t[2] + a * t[3]
               - ps * t[4] + bxy * t[5] + bxz * t[6] + byz * t[7];
        res.sat = 1'b0;
        for (i = 0; i < NUM_DIM; i++)
        begin
            acc[i] = round_frac(acc[i]);
            if (acc[i] > COORD_MAX)
            begin
                acc[i]  = COORD_MAX;
                res.sat = 1'b1;
            end
            else if (acc[i] < COORD_MIN)
            begin
                acc[i]  = COORD_MIN;
                res.sat = 1'b1;
            end
        end
        res.x = coord_t'(acc[0]);
        res.y = coord_t'(acc[1]);
        res.z = coord_t'(acc[2]);
        res.w = coord_t'(acc[3]);
        return res;
    endfunction

    function automatic void compare_field(string field, logic [COORD_WIDTH-1:0] expv,
                                          logic [COORD_WIDTH-1:0] actv);
        if (actv !== expv)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, field, expv, actv);
            mismatch_count++;
        end
    endfunction

    // check results, then record accepted points
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pt_out.valid && pt_out.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: unexpected result expected none actual %h %h %h %h",
                                 $time, pt_out.out_x, pt_out.out_y, pt_out.out_z,
                                 pt_out.out_w);
                    mismatch_count++;
                end
                else
                begin
                    rotated_t exp_pt;
                    exp_pt = expected_points.pop_front();
                    compare_field("out_x", exp_pt.x, pt_out.out_x);
                    compare_field("out_y", exp_pt.y, pt_out.out_y);
                    compare_field("out_z", exp_pt.z, pt_out.out_z);
                    compare_field("out_w", exp_pt.w, pt_out.out_w);
                    compare_field("saturated", exp_pt.sat, pt_out.saturated);
                    if (exp_pt.sat)
                        sat_results++;
                    results_checked++;
                end
            end
            if (pt_in.valid && pt_in.ready)
            begin
                expected_points.push_back(rotate_point('{pt_in.in_x, pt_in.in_y,
                                                         pt_in.in_z, pt_in.in_w},
                                                       active_rotor));
                points_accepted++;
            end
            if (pt_in.valid && !pt_in.ready)
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
            else
                stall_run = 0;
        end
    end

    // receiver flow control; hold-offs override the pattern
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_left = hold_len;
            hold_seen = hold_seq;
        end
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        if (hold_left > 0)
        begin
            pt_out.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  pt_out.ready <= 1'b1;
                RX_RANDOM:  pt_out.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: pt_out.ready <= rx_pattern[0];
                default:    pt_out.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    function automatic point_t make_point(coord_t x, coord_t y, coord_t z, coord_t w);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.w = w;
        return p;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9)) inside
            [0:3]: return coord_t'($urandom);
            9:
            begin
                case ($urandom_range(0, 4))
                    0:       return P_MAX;
                    1:       return P_MIN;
                    2:       return '0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return coord_t'(int'($urandom_range(0, (1 << 21) - 1)) - (1 << 20));
        endcase
    endfunction

    function automatic point_t rand_point();
        return make_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    function automatic coef_t rand_coef(int span);
        if (span == 0 || $urandom_range(0, 5) == 0)
            return '0;
        return coef_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic rotor_t fill_rotor(coef_t v);
        rotor_t r;
        int     i;
        for (i = 0; i < NUM_COEF; i++)
            r[i] = v;
        return r;
    endfunction

    task automatic send_point(input point_t p);
        pt_in.valid <= 1'b1;
        pt_in.in_x  <= p.x;
        pt_in.in_y  <= p.y;
        pt_in.in_z  <= p.z;
        pt_in.in_w  <= p.w;
        offering = 1'b1;
        @(posedge clk);
        while (!pt_in.ready)
            @(posedge clk);
        if (sender_idles)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                pt_in.valid <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 12);
            end
        end
    endtask

    task automatic wait_idle();
        if (offering)
        begin
            pt_in.valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_rotor(input rotor_t r);
        int i;
        wait_idle();
        for (i = 0; i < NUM_COEF; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= coef_idx_t'(i);
            cfg_data  <= r[i];
            @(posedge clk);
            active_rotor[i] = r[i];
        end
        cfg_we <= 1'b0;
        rotor_settings++;
    endtask

    task automatic test_directed();
        rotor_t r;
        sender_idles = 1'b0;
        rx_mode      = RX_ALWAYS;
        // identity rotor straight out of reset
        send_point(make_point('0, '0, '0, '0));
        send_point(make_point(P_MAX, P_MIN, -32'sd1, 32'sd1));
        send_point(make_point(32'shAAAAAAAA, 32'sh55555555, 32'sh00010000, -32'sh00010000));
        send_point(make_point(P_MIN, P_MAX, 32'sh55555555, 32'shAAAAAAAA));
        send_point(make_point(P_MIN, P_MIN, P_MIN, P_MIN));
        // unnormalized rotor, every coefficient at its maximum
        load_rotor(fill_rotor(C_MAX));
        send_point(make_point(P_MAX, P_MAX, P_MAX, P_MAX));
        send_point(make_point(P_MIN, P_MAX, P_MIN, P_MAX));
        send_point(make_point(32'sd1, -32'sd1, 32'sd1, -32'sd1));
        send_point(make_point(32'sh00010000, '0, '0, '0));
        // every coefficient at its minimum
        load_rotor(fill_rotor(C_MIN));
        send_point(make_point(P_MAX, P_MAX, P_MAX, P_MAX));
        send_point(make_point(P_MIN, P_MIN, P_MIN, P_MIN));
        send_point(make_point(-32'sd1, 32'sd1, P_MAX, P_MIN));
        send_point(make_point('0, 32'sh00010000, '0, -32'sh00010000));
        // tiny rotor: products land on half-LSB rounding ties
        r = fill_rotor('0);
        r[REG_SCALAR] = 16'sd1;
        r[REG_PSEUDO] = -16'sd1;
        load_rotor(r);
        send_point(make_point(32'sd8192, -32'sd8192, 32'sd24576, -32'sd24576));
        send_point(make_point(32'sh20000000, -32'sh20000000, 32'sd8191, -32'sd8193));
        send_point(make_point(P_MAX, P_MIN, P_MAX, P_MIN));
        // 90 degrees in the xy plane
        r = fill_rotor('0);
        r[REG_SCALAR] = COS45;
        r[REG_XY]     = COS45;
        load_rotor(r);
        send_point(make_point(32'sh00010000, '0, '0, '0));
        send_point(make_point('0, 32'sh00010000, 32'sh00020000, -32'sh00030000));
        send_point(make_point(P_MAX, P_MIN, '0, '0));
    endtask

    task automatic test_plane_rotations();
        rotor_t r;
        int     plane;
        int     n;
        sender_idles = 1'b1;
        burst_left   = $urandom_range(1, 12);
        for (plane = int'(REG_XY); plane <= int'(REG_PSEUDO); plane++)
        begin
            r = fill_rotor('0);
            case ($urandom_range(0, 2))
                0:
                begin
                    r[REG_SCALAR] = COS45;
                    r[plane]      = COS45;
                end
                1:
                begin
                    r[REG_SCALAR] = 16'sd15137;
                    r[plane]      = -16'sd6270;
                end
                default:
                begin
                    r[REG_SCALAR] = -16'sd6270;
                    r[plane]      = 16'sd15137;
                end
            endcase
            load_rotor(r);
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            for (n = 0; n < 35; n++)
                send_point(rand_point());
        end
    endtask

    task automatic test_random_rotors();
        rotor_t r;
        int     phase;
        int     span;
        int     i;
        int     n;
        sender_idles = 1'b1;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       span = 32767;
                1:       span = 4096;
                2:       span = 11585;
                default: span = ($urandom_range(0, 1) == 0) ? 16384 : 8192;
            endcase
            for (i = 0; i < NUM_COEF; i++)
                r[i] = rand_coef(span);
            load_rotor(r);
            rx_mode = rx_mode_e'(phase % 4);
            for (n = 0; n < 110; n++)
                send_point(rand_point());
        end
    endtask

    task automatic test_backpressure();
        rotor_t r;
        int     i;
        int     round_no;
        int     n;
        for (i = 0; i < NUM_COEF; i++)
            r[i] = rand_coef(16384);
        load_rotor(r);
        sender_idles = 1'b0;
        rx_mode      = RX_RANDOM;
        for (round_no = 0; round_no < 3; round_no++)
        begin
            hold_len = $urandom_range(60, 120);
            hold_seq++;
            for (n = 0; n < 50; n++)
                send_point(rand_point());
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_SCALAR;
        cfg_data     <= '0;
        pt_in.valid  <= 1'b0;
        pt_in.in_x   <= '0;
        pt_in.in_y   <= '0;
        pt_in.in_z   <= '0;
        pt_in.in_w   <= '0;
        active_rotor = fill_rotor('0);
        active_rotor[REG_SCALAR] = ONE;
        rotor_settings = 1;
        rx_mode        = RX_ALWAYS;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_plane_rotations();
        test_random_rotors();
        test_backpressure();
        wait_idle();

        $display("Covered %0d points under %0d rotor settings, %0d of them saturated.",
                 points_accepted, rotor_settings, sat_results);
        $display("Checked %0d results; longest input stall %0d cycles.",
                 results_checked, longest_stall);
        if (mismatch_count == 0)
            $display("rotor4d_vector_rotate: match");
        else
            $display("rotor4d_vector_rotate: mismatch");
        $finish;
    end

endmodule
